@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file lpht_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lpht_pkg.sv @@
`default_nettype none

package lpht_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	localparam int MODE_W = 2;
	localparam int KEY_W  = 31;
	localparam int STAT_W = 3;
	localparam int SLOT_W = 10;
	localparam int SIZE_W = 11;
	localparam int BCNT_W = $clog2(KEY_W);
	localparam int MEM_W  = KEY_W + 1;

	localparam int APB_DW  = 32;
	localparam int APB_AW  = 2;

	localparam logic [APB_AW-1:0] REG_TABLE_SIZE = 2'd0;
	localparam logic [SIZE_W-1:0] SIZE_RESET     = 11'd1024;

	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
	} lpht_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
	} lpht_res_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DIV,
		S_RD,
		S_CHK,
		S_CLR
	} lpht_state_t;

	typedef struct packed {
		logic              load;
		logic              div_step;
		logic              rd;
		logic              adv;
		logic              ins_wr;
		logic              clr_wr;
		logic              emit;
		logic              slot_sel;
		logic [STAT_W-1:0] status;
	} lpht_ctl_t;

	typedef struct packed {
		logic div_last;
		logic hit;
		logic empty;
		logic probe_last;
		logic clr_last;
		logic is_insert;
	} lpht_sts_t;

	// size 0 behaves as 1, anything above the store depth as the depth
	function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
		logic [CNT_W-1:0] n;
		if (size == '0)
			n = CNT_W'(1);
		else if (32'(size) > TABLE_DEPTH)
			n = CNT_W'(TABLE_DEPTH);
		else
			n = CNT_W'(size);
		return n;
	endfunction

endpackage

`default_nettype wire

@@ rtl/lpht_ram.sv @@
`default_nettype none

module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[addr] <= wdata;
			else
				rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/lpht_dp.sv @@
`default_nettype none

module lpht_dp
	import lpht_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lpht_ctl_t         ctl,
	output lpht_sts_t              sts,
	input  wire lpht_cmd_t         cmd,
	input  wire logic [SIZE_W-1:0] size,
	output lpht_res_t              res,
	output logic                   done
);

	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  rem_q;
	logic [BCNT_W-1:0] bitcnt_q;
	logic [IDX_W-1:0]  pos_q;
	logic [CNT_W-1:0]  count_q;
	lpht_res_t         res_q;
	logic              done_q;

	logic [CNT_W-1:0] trial;
	logic [IDX_W-1:0] rem_nxt;
	logic [CNT_W-1:0] pos_inc;
	logic             pos_wrap;

	logic             mem_en;
	logic             mem_we;
	logic [MEM_W-1:0] mem_wdata;
	logic [MEM_W-1:0] mem_rdata;
	logic             rd_valid;
	logic [KEY_W-1:0] rd_key;

	// restoring divider, one key bit per step, msb first
	assign trial   = {rem_q, key_q[bitcnt_q]};
	assign rem_nxt = (trial >= n_q) ? IDX_W'(trial - n_q) : trial[IDX_W-1:0];

	assign pos_inc  = {1'b0, pos_q} + CNT_W'(1);
	assign pos_wrap = (pos_inc == n_q);

	// word layout: valid bit over key
	assign mem_we    = ctl.clr_wr | ctl.ins_wr;
	assign mem_en    = mem_we | ctl.rd;
	assign mem_wdata = ctl.clr_wr ? '0 : {1'b1, key_q};
	assign rd_valid  = mem_rdata[MEM_W-1];
	assign rd_key    = mem_rdata[KEY_W-1:0];

	lpht_ram #(
		.WIDTH (MEM_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (pos_q),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitcnt_q <= '0;
			pos_q    <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= ctl.emit;
			if (ctl.load) begin
				bitcnt_q <= BCNT_W'(KEY_W - 1);
				pos_q    <= '0;
				count_q  <= '0;
			end else if (ctl.div_step) begin
				bitcnt_q <= bitcnt_q - BCNT_W'(1);
				if (sts.div_last)
					pos_q <= rem_nxt;
			end else if (ctl.adv) begin
				pos_q   <= pos_wrap ? '0 : pos_inc[IDX_W-1:0];
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.clr_wr) begin
				pos_q <= pos_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q <= cmd.mode;
			key_q  <= cmd.key;
			n_q    <= eff_size(size);
			rem_q  <= '0;
		end else if (ctl.div_step) begin
			rem_q <= rem_nxt;
		end
		if (ctl.emit) begin
			res_q.status <= ctl.status;
			res_q.slot   <= ctl.slot_sel ? SLOT_W'(pos_q) : '0;
		end
	end

	assign sts.div_last   = (bitcnt_q == '0);
	assign sts.hit        = rd_valid && (rd_key == key_q);
	assign sts.empty      = !rd_valid;
	assign sts.probe_last = (count_q == (n_q - CNT_W'(1)));
	assign sts.clr_last   = (pos_q == IDX_W'(TABLE_DEPTH - 1));
	assign sts.is_insert  = (mode_q == MODE_INSERT);

	assign res  = res_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ rtl/lpht_ctrl.sv @@
`default_nettype none

module lpht_ctrl
	import lpht_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MODE_W-1:0] mode,
	input  wire lpht_sts_t         sts,
	output lpht_ctl_t              ctl,
	output logic                   busy
);

	lpht_state_t state_q;
	lpht_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_INIT;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			S_INIT: begin
				// sweep after reset, no result
				ctl.clr_wr = 1'b1;
				if (sts.clr_last)
					state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					ctl.load  = 1'b1;
					state_nxt = (mode == MODE_CLEAR) ? S_CLR : S_DIV;
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last)
					state_nxt = S_RD;
			end
			S_RD: begin
				ctl.rd    = 1'b1;
				state_nxt = S_CHK;
			end
			S_CHK: begin
				if (sts.is_insert) begin
					if (sts.empty) begin
						ctl.ins_wr   = 1'b1;
						ctl.emit     = 1'b1;
						ctl.slot_sel = 1'b1;
						ctl.status   = ST_INSERTED;
						state_nxt    = S_IDLE;
					end else if (sts.hit) begin
						ctl.emit     = 1'b1;
						ctl.slot_sel = 1'b1;
						ctl.status   = ST_FOUND;
						state_nxt    = S_IDLE;
					end else if (sts.probe_last) begin
						ctl.emit   = 1'b1;
						ctl.status = ST_FULL;
						state_nxt  = S_IDLE;
					end else begin
						ctl.adv   = 1'b1;
						state_nxt = S_RD;
					end
				end else begin
					// lookup walks past empty slots
					if (sts.hit) begin
						ctl.emit     = 1'b1;
						ctl.slot_sel = 1'b1;
						ctl.status   = ST_FOUND;
						state_nxt    = S_IDLE;
					end else if (sts.probe_last) begin
						ctl.emit   = 1'b1;
						ctl.status = ST_NOT_FOUND;
						state_nxt  = S_IDLE;
					end else begin
						ctl.adv   = 1'b1;
						state_nxt = S_RD;
					end
				end
			end
			S_CLR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					ctl.emit   = 1'b1;
					ctl.status = ST_CLEARED;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_INIT;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/linear_probe_hash_table.sv @@
`default_nettype none

// Key table with open addressing and linear probing over a 1024-entry store.
// After reset the block sweeps the store empty with busy high; configuration
// writes are taken during that time. A command is taken when start is high
// and busy is low. A lookup or insert first runs the bit-serial divider that
// forms the home slot (key mod table size), then probes slot after slot,
// each probe being a registered read of the single-port store; the result
// appears on res with done high for one cycle. A probe run takes up to the
// table size in probes for a lookup miss or a full table. A clear rewrites all
// 1024 entries before it reports. The result is shown for exactly one cycle
// and cannot be held off, so the receiver must take it when done is high.
// table_size is at APB address 0; write it only while busy is low.
module linear_probe_hash_table_top
	import lpht_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire lpht_cmd_t         cmd,
	output logic                   done,
	output lpht_res_t              res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	logic [SIZE_W-1:0] size_q;
	logic              reg_wr;
	lpht_ctl_t         ctl;
	lpht_sts_t         sts;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && (paddr == REG_TABLE_SIZE);
	assign prdata = (paddr == REG_TABLE_SIZE) ? APB_DW'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= SIZE_RESET;
		else if (reg_wr)
			size_q <= pwdata[SIZE_W-1:0];
	end

	lpht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (cmd.mode),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	lpht_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.cmd    (cmd),
		.size   (size_q),
		.res    (res),
		.done   (done)
	);

endmodule

`default_nettype wire

@@ rtl/lpht_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module lpht_checker
	import lpht_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire lpht_cmd_t cmd,
	input wire logic      done,
	input wire lpht_res_t res
);

	logic res_noslot;

	assign res_noslot = (res.status == ST_NOT_FOUND) || (res.status == ST_FULL) ||
		(res.status == ST_CLEARED);

	// a taken command holds the block busy
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "command not held busy")

	// a result closes its command
	`ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy && $past(busy), "result out of step")

	// one beat per command
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result repeated")

	// misses, full and clear report slot zero
	`ASSERT_IMPLY(a_slot_zero, clk, arst_n, done && res_noslot, res.slot == '0,
		"slot set without a hit")

	// a clear sweeps the whole store, so no result follows straight away
	`ASSERT_NEXT(a_clear_slow, clk, arst_n, start && !busy && (cmd.mode == MODE_CLEAR),
		!done, "clear answered at once")

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.res    (res)
);

`default_nettype wire
